/* hdl/lzsd_pkg.sv */
// shared types and constants of the lzss stream decoder
`timescale 1ns / 1ps
`default_nettype none

package lzsd_pkg;

  localparam int CFG_W     = 24;
  localparam int BYTE_W    = 8;
  localparam int LIT_BITS  = 8;
  localparam int MIN_MATCH = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SIZE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_RD,
    S_WR,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              stream_end;
    status_t           status;
    logic              run_last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/lzsd_ifs.sv */
// valid/ready channel interfaces for compressed input and decoded output
`timescale 1ns / 1ps
`default_nettype none

interface lzsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [lzsd_pkg::BYTE_W-1:0] compressed_byte;
  logic                        last_byte;

  modport source (output valid, output compressed_byte, output last_byte, input ready);
  modport sink (input valid, input compressed_byte, input last_byte, output ready);
endinterface

interface lzsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lzsd_pkg::BYTE_W-1:0] out_byte;
  logic                        byte_valid;
  logic                        stream_end;
  logic [1:0]                  status;
  logic                        run_last;

  modport source (output valid, output out_byte, output byte_valid, output stream_end,
                  output status, output run_last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input stream_end,
                input status, input run_last, output ready);
endinterface

`default_nettype wire

/* hdl/lzsd_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/lzsd_dict.sv */
// dictionary memory with fill tracking so unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module lzsd_dict #(
  parameter int OFFSET_BITS = 13
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [OFFSET_BITS-1:0]      rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [OFFSET_BITS-1:0]      wr_addr,
  input  wire logic [lzsd_pkg::BYTE_W-1:0] wr_data,
  output logic      [lzsd_pkg::BYTE_W-1:0] rd_data
);

  // writes start at entry 1 and move up one at a time, entry 0 only after a wrap
  logic [OFFSET_BITS:0]          fill;
  logic                          full;
  logic                          rd_ok;
  logic [lzsd_pkg::BYTE_W-1:0]   ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= (OFFSET_BITS+1)'(1);
      full  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_addr == '0) begin
          full <= 1'b1;
        end else if ({1'b0, wr_addr} == fill) begin
          fill <= fill + (OFFSET_BITS+1)'(1);
        end
      end
      if (rd_en) begin
        rd_ok <= full || (rd_addr != '0 && {1'b0, rd_addr} < fill);
      end
    end
  end

  lzsd_ram #(
    .WIDTH (lzsd_pkg::BYTE_W),
    .DEPTH (2 ** OFFSET_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign rd_data = rd_ok ? ram_q : '0;

endmodule

`default_nettype wire

/* hdl/lzsd_ctrl.sv */
// bit-serial token parser and copy sequencer with result hold and output register
`timescale 1ns / 1ps
`default_nettype none

module lzsd_ctrl #(
  parameter int OFFSET_BITS       = 13,
  parameter int LENGTH_FIELD_BITS = 4,
  parameter int COUNT_BITS        = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lzsd_in_if.sink                          compressed,
  lzsd_out_if.source                       decompressed,
  input  wire logic [lzsd_pkg::CFG_W-1:0]  expected_size,
  output logic                             dict_rd_en,
  output logic      [OFFSET_BITS-1:0]      dict_rd_addr,
  output logic                             dict_wr_en,
  output logic      [OFFSET_BITS-1:0]      dict_wr_addr,
  output logic      [lzsd_pkg::BYTE_W-1:0] dict_wr_data,
  input  wire logic [lzsd_pkg::BYTE_W-1:0] dict_rd_data
);

  localparam int TOK_W = OFFSET_BITS + LENGTH_FIELD_BITS;
  localparam int PH_W  = $clog2(TOK_W + 2);
  localparam int LEN_W = LENGTH_FIELD_BITS + 1;
  localparam int CMP_W = (COUNT_BITS > lzsd_pkg::CFG_W) ? COUNT_BITS : lzsd_pkg::CFG_W;
  localparam logic [PH_W-1:0] PH_LIT = PH_W'(lzsd_pkg::LIT_BITS + 1);
  localparam logic [PH_W-1:0] PH_OFF = PH_W'(OFFSET_BITS + 1);
  localparam logic [PH_W-1:0] PH_TOK = PH_W'(TOK_W + 1);

  lzsd_pkg::state_t state, state_next;

  logic [lzsd_pkg::BYTE_W-1:0] sh, sh_next;
  logic [3:0]                  bit_left, bit_left_next;
  logic                        last, last_next;
  logic [TOK_W-1:0]            token_bits, token_bits_next;
  logic [PH_W-1:0]             token_phase, token_phase_next;
  logic                        token_literal, token_literal_next;
  logic [OFFSET_BITS-1:0]      dict_head, dict_head_next;
  logic [COUNT_BITS-1:0]       out_count, out_count_next;
  logic                        discarding, discarding_next;
  logic [OFFSET_BITS-1:0]      copy_addr, copy_addr_next;
  logic [LEN_W-1:0]            copy_left, copy_left_next;
  logic                        hold_v, hold_v_next;
  lzsd_pkg::res_t              hold_res, hold_res_next;
  logic                        out_v, out_v_next;
  lzsd_pkg::res_t              out_res, out_res_next;

  logic                        out_free;
  logic                        can_push;
  logic                        cur_bit;
  logic [TOK_W-1:0]            tb_shift;
  logic [PH_W-1:0]             ph_inc;
  logic                        overflow;
  logic                        put_req;
  logic [lzsd_pkg::BYTE_W-1:0] put_val;
  logic                        end_req;
  lzsd_pkg::status_t           end_status;
  logic                        push;
  lzsd_pkg::res_t              push_res;
  logic                        ended;
  logic                        rearm;
  logic                        out_load;

  assign out_free = !out_v || decompressed.ready;
  assign can_push = !hold_v || out_free;
  assign cur_bit  = (bit_left != '0) ? sh[lzsd_pkg::BYTE_W-1] : 1'b0;
  assign tb_shift = {token_bits[TOK_W-2:0], cur_bit};
  assign ph_inc   = token_phase + PH_W'(1);
  assign overflow = CMP_W'(out_count) >= CMP_W'(expected_size);

  always_comb begin
    state_next         = state;
    sh_next            = sh;
    bit_left_next      = bit_left;
    last_next          = last;
    token_bits_next    = token_bits;
    token_phase_next   = token_phase;
    token_literal_next = token_literal;
    dict_head_next     = dict_head;
    out_count_next     = out_count;
    discarding_next    = discarding;
    copy_addr_next     = copy_addr;
    copy_left_next     = copy_left;
    hold_v_next        = hold_v;
    hold_res_next      = hold_res;
    out_res_next       = out_res;
    dict_rd_en         = 1'b0;
    dict_rd_addr       = copy_addr;
    dict_wr_en         = 1'b0;
    dict_wr_addr       = dict_head;
    dict_wr_data       = '0;
    put_req            = 1'b0;
    put_val            = '0;
    end_req            = 1'b0;
    end_status         = lzsd_pkg::ST_OK;
    push               = 1'b0;
    push_res           = '0;
    ended              = 1'b0;
    rearm              = 1'b0;
    out_load           = 1'b0;

    unique case (state)
      lzsd_pkg::S_IDLE: begin
        if (compressed.valid) begin
          if (discarding) begin
            rearm = compressed.last_byte;
          end else begin
            sh_next       = compressed.compressed_byte;
            bit_left_next = 4'(lzsd_pkg::BYTE_W);
            last_next     = compressed.last_byte;
            state_next    = lzsd_pkg::S_BIT;
          end
        end
      end
      lzsd_pkg::S_BIT: begin
        if (bit_left == '0 && !last) begin
          state_next = lzsd_pkg::S_FLUSH;
        end else if (can_push) begin
          // once the byte is used up on a last item, zero bits keep coming
          if (bit_left != '0) begin
            bit_left_next = bit_left - 4'd1;
          end
          sh_next = sh << 1;
          if (token_phase == '0) begin
            token_literal_next = cur_bit;
            token_bits_next    = '0;
            token_phase_next   = PH_W'(1);
          end else begin
            token_bits_next  = tb_shift;
            token_phase_next = ph_inc;
            if (token_literal && ph_inc == PH_LIT) begin
              token_phase_next = '0;
              put_req          = 1'b1;
              put_val          = tb_shift[lzsd_pkg::BYTE_W-1:0];
            end else if (!token_literal && ph_inc == PH_OFF &&
                         tb_shift[OFFSET_BITS-1:0] == '0) begin
              // zero offset is the end marker
              token_phase_next = '0;
              end_req          = 1'b1;
              end_status       = (CMP_W'(out_count) == CMP_W'(expected_size)) ?
                                 lzsd_pkg::ST_OK : lzsd_pkg::ST_SIZE;
            end else if (!token_literal && ph_inc == PH_TOK) begin
              token_phase_next = '0;
              copy_addr_next   = tb_shift[TOK_W-1:LENGTH_FIELD_BITS];
              copy_left_next   = LEN_W'(tb_shift[LENGTH_FIELD_BITS-1:0]) +
                                 LEN_W'(lzsd_pkg::MIN_MATCH);
              state_next       = lzsd_pkg::S_RD;
            end
          end
        end
      end
      lzsd_pkg::S_RD: begin
        dict_rd_en = 1'b1;
        state_next = lzsd_pkg::S_WR;
      end
      lzsd_pkg::S_WR: begin
        if (can_push) begin
          put_req        = 1'b1;
          put_val        = dict_rd_data;
          copy_addr_next = copy_addr + OFFSET_BITS'(1);
          copy_left_next = copy_left - LEN_W'(1);
          state_next     = (copy_left == LEN_W'(1)) ? lzsd_pkg::S_BIT : lzsd_pkg::S_RD;
        end
      end
      lzsd_pkg::S_FLUSH: begin
        if (!hold_v) begin
          state_next = lzsd_pkg::S_IDLE;
        end else if (out_free) begin
          out_load              = 1'b1;
          out_res_next          = hold_res;
          out_res_next.run_last = 1'b1;
          hold_v_next           = 1'b0;
          state_next            = lzsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lzsd_pkg::S_IDLE;
      end
    endcase

    if (put_req) begin
      push = 1'b1;
      if (overflow) begin
        push_res.stream_end = 1'b1;
        push_res.status     = lzsd_pkg::ST_OVERFLOW;
        ended               = 1'b1;
      end else begin
        push_res.out_byte   = put_val;
        push_res.byte_valid = 1'b1;
        dict_wr_en          = 1'b1;
        dict_wr_data        = put_val;
        dict_head_next      = dict_head + OFFSET_BITS'(1);
        out_count_next      = out_count + COUNT_BITS'(1);
      end
    end

    if (end_req) begin
      push                = 1'b1;
      push_res.stream_end = 1'b1;
      push_res.status     = end_status;
      ended               = 1'b1;
    end

    // the newest result waits in hold until we know whether it closes the item
    if (push) begin
      if (hold_v) begin
        out_load              = 1'b1;
        out_res_next          = hold_res;
        out_res_next.run_last = 1'b0;
      end
      hold_res_next = push_res;
      hold_v_next   = 1'b1;
    end

    if (ended) begin
      state_next = lzsd_pkg::S_FLUSH;
      if (last) begin
        rearm = 1'b1;
      end else begin
        discarding_next = 1'b1;
      end
    end

    if (rearm) begin
      dict_head_next     = OFFSET_BITS'(1);
      token_bits_next    = '0;
      token_phase_next   = '0;
      token_literal_next = 1'b0;
      out_count_next     = '0;
      discarding_next    = 1'b0;
    end

    out_v_next = out_load ? 1'b1 : (decompressed.ready ? 1'b0 : out_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lzsd_pkg::S_IDLE;
      token_bits    <= '0;
      token_phase   <= '0;
      token_literal <= 1'b0;
      dict_head     <= OFFSET_BITS'(1);
      out_count     <= '0;
      discarding    <= 1'b0;
      hold_v        <= 1'b0;
      out_v         <= 1'b0;
    end else begin
      state         <= state_next;
      token_bits    <= token_bits_next;
      token_phase   <= token_phase_next;
      token_literal <= token_literal_next;
      dict_head     <= dict_head_next;
      out_count     <= out_count_next;
      discarding    <= discarding_next;
      hold_v        <= hold_v_next;
      out_v         <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    sh        <= sh_next;
    bit_left  <= bit_left_next;
    last      <= last_next;
    copy_addr <= copy_addr_next;
    copy_left <= copy_left_next;
    hold_res  <= hold_res_next;
    out_res   <= out_res_next;
  end

  assign compressed.ready        = (state == lzsd_pkg::S_IDLE);
  assign decompressed.valid      = out_v;
  assign decompressed.out_byte   = out_res.out_byte;
  assign decompressed.byte_valid = out_res.byte_valid;
  assign decompressed.stream_end = out_res.stream_end;
  assign decompressed.status     = out_res.status;
  assign decompressed.run_last   = out_res.run_last;

`ifndef SYNTHESIS
  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    out_v && out_res.stream_end |-> !out_res.byte_valid)
    else $error("stream end result carries a data byte");

  a_wr_within_size: assert property (@(posedge clk) disable iff (rst)
    dict_wr_en |-> CMP_W'(out_count) < CMP_W'(expected_size))
    else $error("dictionary written past expected size");

  a_copy_left: assert property (@(posedge clk) disable iff (rst)
    (state == lzsd_pkg::S_RD || state == lzsd_pkg::S_WR) |-> copy_left != '0)
    else $error("copy running with no bytes left");

  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    hold_v && hold_res.stream_end |-> state == lzsd_pkg::S_FLUSH)
    else $error("parsing continues after stream end");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == lzsd_pkg::S_WR |-> $past(state) == lzsd_pkg::S_RD ||
                                $past(state) == lzsd_pkg::S_WR)
    else $error("copy write without a dictionary read");
`endif

endmodule

`default_nettype wire

/* hdl/lzsd_ifs_placeholder.sv */
// configuration register holding the expected decoded stream size
`timescale 1ns / 1ps
`default_nettype none

module lzsd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [lzsd_pkg::CFG_W-1:0] wr_data,
  output logic      [lzsd_pkg::CFG_W-1:0] expected_size
);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= '0;
    end else if (wr_en) begin
      expected_size <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/lzss_stream_decoder_top.sv */
// lzss stream decoder: one compressed byte per item, decoded bytes and stream status out
// steps: a byte is taken in idle, then its 8 bits are parsed one at a time (more on a last byte in
// zero fill), the byte is seen used up and its final result handed on; a copied byte takes a
// dictionary read, then a write, and the next byte is accepted only after all of this
// rate: one byte at a time; reset is synchronous and clears parser, counters and output, and
// a fill count makes the dictionary read as zero until written, so no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module lzss_stream_decoder_top #(
  parameter int OFFSET_BITS       = 13,
  parameter int LENGTH_FIELD_BITS = 4,
  parameter int COUNT_BITS        = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lzsd_in_if.sink                         compressed,
  lzsd_out_if.source                      decompressed,
  input  wire logic                       cfg_wr_en,
  input  wire logic [lzsd_pkg::CFG_W-1:0] cfg_wr_data
);

  logic [lzsd_pkg::CFG_W-1:0]  expected_size;
  logic                        dict_rd_en;
  logic [OFFSET_BITS-1:0]      dict_rd_addr;
  logic                        dict_wr_en;
  logic [OFFSET_BITS-1:0]      dict_wr_addr;
  logic [lzsd_pkg::BYTE_W-1:0] dict_wr_data;
  logic [lzsd_pkg::BYTE_W-1:0] dict_rd_data;

  lzsd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_wr_en),
    .wr_data       (cfg_wr_data),
    .expected_size (expected_size)
  );

  lzsd_ctrl #(
    .OFFSET_BITS       (OFFSET_BITS),
    .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS),
    .COUNT_BITS        (COUNT_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .compressed    (compressed),
    .decompressed  (decompressed),
    .expected_size (expected_size),
    .dict_rd_en    (dict_rd_en),
    .dict_rd_addr  (dict_rd_addr),
    .dict_wr_en    (dict_wr_en),
    .dict_wr_addr  (dict_wr_addr),
    .dict_wr_data  (dict_wr_data),
    .dict_rd_data  (dict_rd_data)
  );

  lzsd_dict #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dict (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (dict_rd_en),
    .rd_addr (dict_rd_addr),
    .wr_en   (dict_wr_en),
    .wr_addr (dict_wr_addr),
    .wr_data (dict_wr_data),
    .rd_data (dict_rd_data)
  );

endmodule

`default_nettype wire
